>>> design/smvm_pkg.sv
// Shared types and constants for the sparse matrix-vector multiply block.
package smvm_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  localparam int unsigned COL_W   = 12;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned VLEN_W  = 13;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd4096;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // One input beat
  typedef struct packed {
    logic [1:0]              operation;
    logic [COL_W-1:0]        column;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
    logic                    row_last;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic signed [SUM_W-1:0] row_sum;
    logic                    bad_column;
  } out_item_t;

  // Item leaving the vector read stage toward the multiply-accumulate
  typedef struct packed {
    logic                    is_empty;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    col_ok;
  } rd_stage_t;

  // Item held in the product stage
  typedef struct packed {
    logic             is_empty;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             col_ok;
  } mul_stage_t;

endpackage

>>> design/smvm_mac.sv
// Multiply stage, saturating row accumulator and result register.
module smvm_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  smvm_pkg::rd_stage_t          up,
  input  logic [smvm_pkg::VAL_W-1:0]   x_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output smvm_pkg::out_item_t          out_data
);
  import smvm_pkg::*;

  logic                    s2_v;
  mul_stage_t              s2;
  logic signed [SUM_W-1:0] prod;
  logic signed [SUM_W-1:0] acc;
  logic                    bad_flag;

  logic                    s2_emits;
  logic                    out_free;
  logic                    s2_go;
  logic                    s2_free;
  logic signed [SUM_W-1:0] addend;
  logic signed [SUM_W-1:0] raw_sum;
  logic signed [SUM_W-1:0] acc_next;
  logic                    bad_next;

  // Stage handshake: a row result needs a free output register
  assign s2_emits = s2.is_empty || s2.last;
  assign out_free = !out_valid || out_ready;
  assign s2_go    = s2_v && (!s2_emits || out_free);
  assign s2_free  = !s2_v || s2_go;
  assign up_ready = s2_free;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s2_free) begin
      s2.is_empty <= up.is_empty;
      s2.row      <= up.row;
      s2.last     <= up.last;
      s2.col_ok   <= up.col_ok;
      prod        <= $signed(up.value) * $signed(x_data);
    end
  end

  // Saturating accumulate; a bad column adds nothing and sets the flag
  always_comb begin
    addend  = s2.col_ok ? prod : '0;
    raw_sum = acc + addend;
    if ((acc[SUM_W-1] == addend[SUM_W-1]) && (raw_sum[SUM_W-1] != acc[SUM_W-1])) begin
      acc_next = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_next = raw_sum;
    end
    bad_next = bad_flag || !s2.col_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      bad_flag <= 1'b0;
    end else if (s2_go && !s2.is_empty) begin
      if (s2.last) begin
        acc      <= '0;
        bad_flag <= 1'b0;
      end else begin
        acc      <= acc_next;
        bad_flag <= bad_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emits) begin
      out_data.out_row <= s2.row;
      if (s2.is_empty) begin
        out_data.row_sum    <= '0;
        out_data.bad_column <= 1'b0;
      end else begin
        out_data.row_sum    <= acc_next;
        out_data.bad_column <= bad_next;
      end
    end
  end

  // Closing a row leaves a clean accumulator
  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    (s2_go && !s2.is_empty && s2.last) |=> (acc == '0) && !bad_flag)
    else $error("accumulator not cleared after row end");

  // An empty row always reports zero with no flag
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (s2_go && s2.is_empty) |=> out_valid && (out_data.row_sum == '0) && !out_data.bad_column)
    else $error("empty row result not zero");

  // A stalled product stage keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_v && !s2_go) |=> s2_v && $stable(s2) && $stable(prod))
    else $error("product stage lost an item while stalled");

endmodule

>>> design/sparse_matrix_vector_multiply.sv
// Sparse matrix times dense vector: vector store, read stage and top-level ports.
// Flow: a nonzero or empty-row beat reads its vector word into the read stage when it is
//   accepted, is multiplied in the product stage, then shows its result, if any, in the
//   output register; a full output register can stall it in either stage.
// Throughput: one beat per cycle while results are taken, set by the saturating accumulator
//   loop and the one read port of the vector memory; loads write the memory on acceptance.
// Reset clears stage valids, accumulator, bad-column flag and sets vector_length to
//   4096; the vector memory is not cleared and entries must be loaded before use.
module sparse_matrix_vector_multiply #(
  parameter int unsigned VECTOR_DEPTH = 4096,
  parameter int unsigned MAX_ROWS     = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smvm_pkg::VLEN_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  smvm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output smvm_pkg::out_item_t           out_data
);
  import smvm_pkg::*;

  localparam int unsigned AW = $clog2(VECTOR_DEPTH);
  localparam logic [16:0] VecDepthW = 17'(VECTOR_DEPTH);
  localparam logic [16:0] MaxRowsW  = 17'(MAX_ROWS);

  logic [VLEN_W-1:0] vector_length;
  logic [VAL_W-1:0]  vec_mem [VECTOR_DEPTH];
  logic [VAL_W-1:0]  x_data;

  logic              s1_v;
  rd_stage_t         s1;
  logic              s1_ready;

  logic              in_fire;
  logic [AW-1:0]     addr;
  logic [16:0]       col_ext;
  logic              col_in_depth;
  logic              col_ok;
  logic              row_ok;
  logic              is_load;
  logic              enter_s1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_RESET;
    end else if (cfg_we) begin
      vector_length <= cfg_data;
    end
  end

  // Input decode
  assign in_ready     = !s1_v || s1_ready;
  assign in_fire      = in_valid && in_ready;
  assign addr         = AW'(in_data.column);
  assign col_ext      = 17'(in_data.column);
  assign col_in_depth = col_ext < VecDepthW;
  assign col_ok       = col_in_depth && (col_ext < 17'(vector_length));
  assign row_ok       = 17'(in_data.row) < MaxRowsW;
  assign is_load      = in_data.operation == OP_LOAD;
  assign enter_s1     = in_fire && row_ok &&
                        ((in_data.operation == OP_NONZERO) || (in_data.operation == OP_EMPTY));

  // Vector memory: load writes, nonzero and empty-row beats read with registered data
  always_ff @(posedge clk) begin
    if (in_fire && is_load && col_in_depth) begin
      vec_mem[addr] <= in_data.value;
    end
    if (enter_s1) begin
      x_data <= vec_mem[addr];
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_ready) begin
      s1_v <= enter_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (enter_s1) begin
      s1.is_empty <= in_data.operation == OP_EMPTY;
      s1.row      <= in_data.row;
      s1.value    <= in_data.value;
      s1.last     <= in_data.row_last;
      s1.col_ok   <= col_ok;
    end
  end

  smvm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s1_v),
    .up_ready  (s1_ready),
    .up        (s1),
    .x_data    (x_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A stalled read stage keeps its item and its vector word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !s1_ready) |=> s1_v && $stable(s1) && $stable(x_data))
    else $error("read stage lost an item while stalled");

  // Loads and ignored beats never enter the pipeline
  a_load_skips: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !enter_s1) |=> !s1_v)
    else $error("non-arithmetic beat entered the read stage");

  // Configuration write lands next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> vector_length == $past(cfg_data))
    else $error("vector_length write lost");

endmodule

>>> dv/sparse_matrix_vector_multiply_test.sv
// Self-checking testbench for the sparse matrix times dense vector block.
module sparse_matrix_vector_multiply_test;
  import smvm_pkg::*;

  localparam int VECTOR_DEPTH = 4096;
  localparam int SETTLE_CYCLES = 8;       // pipeline is three stages deep
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [VLEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  sparse_matrix_vector_multiply i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mirror of the block state
  logic signed [VAL_W-1:0] x_mem [VECTOR_DEPTH];
  bit x_loaded [VECTOR_DEPTH];
  int loaded_cols [$];
  logic signed [SUM_W-1:0] row_acc = '0;
  logic row_bad = 1'b0;
  logic [VLEN_W-1:0] vlen = VLEN_RESET;

  out_item_t pending_sums [$];

  // Run statistics
  int cycles = 0;
  int beats_sent = 0;
  int sums_seen = 0;
  int bad_rows = 0;
  int saturated_sums = 0;
  int vlen_writes = 0;
  int input_stalls = 0;
  int mismatches = 0;

  // Idle controls, shared by stimulus and receiver
  int src_idle_pct = 33;
  int sink_idle_pct = 33;
  int hold_req_len = 0;
  int hold_req_seq = 0;
  int hold_seen_seq = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d row sums outstanding", cycles,
               pending_sums.size());
      $display("[sparse_matrix_vector_multiply] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq = hold_req_seq;
      hold_left = hold_req_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Saturating Q32.32 add
  function automatic logic signed [SUM_W-1:0] add_clamped(
      input logic signed [SUM_W-1:0] a, input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
      s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
    return s;
  endfunction

  function automatic int column_limit();
    return (int'(vlen) < VECTOR_DEPTH) ? int'(vlen) : VECTOR_DEPTH;
  endfunction

  // Updates the mirrored state for one accepted beat and queues any row sum
  function automatic void accumulate_row_sum(input in_item_t b);
    logic signed [SUM_W-1:0] prod;
    out_item_t r;
    case (op_t'(b.operation))
      OP_LOAD: begin
        x_mem[b.column] = b.value;
        if (!x_loaded[b.column]) loaded_cols.push_back(int'(b.column));
        x_loaded[b.column] = 1'b1;
      end
      OP_EMPTY: begin
        r.out_row = b.row;
        r.row_sum = '0;
        r.bad_column = 1'b0;
        pending_sums.push_back(r);
      end
      OP_NONZERO: begin
        if (int'(b.column) < column_limit()) begin
          prod = $signed(b.value) * $signed(x_mem[b.column]);
          row_acc = add_clamped(row_acc, prod);
        end else begin
          row_bad = 1'b1;
        end
        if (b.row_last) begin
          r.out_row = b.row;
          r.row_sum = row_acc;
          r.bad_column = row_bad;
          pending_sums.push_back(r);
          if (row_bad) bad_rows++;
          if (row_acc == SUM_MAX || row_acc == SUM_MIN) saturated_sums++;
          row_acc = '0;
          row_bad = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin : check_sums
    out_item_t want;
    if (!rst && in_valid && !in_ready) input_stalls++;
    if (!rst && out_valid && out_ready) begin
      sums_seen++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected row sum: row %0d sum %h bad %0b", out_data.out_row,
                   out_data.row_sum, out_data.bad_column);
      end else begin
        want = pending_sums.pop_front();
        if (out_data.out_row !== want.out_row || out_data.row_sum !== want.row_sum ||
            out_data.bad_column !== want.bad_column) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"row sum mismatch: expected row %0d sum %h bad %0b,",
                      " got row %0d sum %h bad %0b"},
                     want.out_row, want.row_sum, want.bad_column, out_data.out_row,
                     out_data.row_sum, out_data.bad_column);
        end
      end
    end
  end

  // Offer one beat and wait for its acceptance edge
  task automatic send_beat(input in_item_t b);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_row_sum(b);
    if (op_t'(b.operation) != OP_UNUSED) beats_sent++;
  endtask

  function automatic in_item_t make_beat(input op_t op, input int col, input int row,
                                         input logic [VAL_W-1:0] val, input bit last);
    in_item_t b;
    b.operation = op;
    b.column = COL_W'(col);
    b.row = ROW_W'(row);
    b.value = val;
    b.row_last = last;
    return b;
  endfunction

  // Mix of extremes, small magnitudes and full-range values
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      3, 4, 5: return VAL_W'($signed($urandom_range(0, 524287)) - 262144);
      default: return $urandom;
    endcase
  endfunction

  // Bad column now and then; good columns are always loaded before use
  task automatic pick_column(output int c);
    int lim;
    lim = column_limit();
    if (lim == 0) begin
      c = $urandom_range(0, VECTOR_DEPTH - 1);
    end else if (lim < VECTOR_DEPTH && $urandom_range(0, 99) < 10) begin
      c = $urandom_range(lim, VECTOR_DEPTH - 1);
    end else begin
      c = VECTOR_DEPTH;
      if (loaded_cols.size() > 0 && $urandom_range(0, 1))
        c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
      if (c >= lim) c = $urandom_range(0, lim - 1);
      if (!x_loaded[c]) send_beat(make_beat(OP_LOAD, c, $urandom_range(0, 4095),
                                            pick_value(), $urandom_range(0, 1)));
    end
  endtask

  // A well-formed row of nz nonzeros; mixed rows change the row index midway
  task automatic send_row(input int nz, input bit mixed);
    int r;
    int c;
    r = $urandom_range(0, 4095);
    for (int k = 0; k < nz; k++) begin
      pick_column(c);
      if (mixed && $urandom_range(0, 2) == 0) r = $urandom_range(0, 4095);
      send_beat(make_beat(OP_NONZERO, c, r, pick_value(), k == nz - 1));
    end
  endtask

  // One random item: mostly whole rows, some loads, empty rows and noise
  task automatic send_random_item();
    int kind;
    int c;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      send_row($urandom_range(1, 6), 1'b0);
    end else if (kind < 66) begin
      send_row($urandom_range(2, 5), 1'b1);
    end else if (kind < 78) begin
      send_beat(make_beat(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          pick_value(), $urandom_range(0, 1)));
    end else if (kind < 90) begin
      send_beat(make_beat(OP_EMPTY, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom, $urandom_range(0, 1)));
    end else if (kind < 95) begin
      // unused operation, should leave everything alone
      send_beat(make_beat(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom, $urandom_range(0, 1)));
    end else begin
      // broken row: a nonzero without row_last carries into the next row
      pick_column(c);
      send_beat(make_beat(OP_NONZERO, c, $urandom_range(0, 4095), pick_value(), 1'b0));
    end
  endtask

  // Stop offering and let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_sums.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vector_length(input logic [VLEN_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vlen = v;
    vlen_writes++;
  endtask

  // Extremes, each operation, saturation, empty row inside a row, mixed rows
  task automatic test_directed_cases();
    send_beat(make_beat(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 1'b0));
    send_beat(make_beat(OP_LOAD, 4095, 4095, 32'h8000_0000, 1'b1));
    send_beat(make_beat(OP_LOAD, 1, 0, 32'h0001_0000, 1'b0));
    send_beat(make_beat(OP_LOAD, 2, 0, 32'h8000_0000, 1'b0));
    send_beat(make_beat(OP_LOAD, 3, 0, 32'hFFFF_FFFF, 1'b0));
    // 2.0 * 1.0
    send_beat(make_beat(OP_NONZERO, 1, 0, 32'h0002_0000, 1'b1));
    // extreme columns, rows and values
    send_beat(make_beat(OP_NONZERO, 0, 4095, 32'h7FFF_FFFF, 1'b0));
    send_beat(make_beat(OP_NONZERO, 4095, 4095, 32'h8000_0000, 1'b1));
    // empty row in the middle of a pending row, then a row that ends on another index
    send_beat(make_beat(OP_NONZERO, 3, 7, 32'hFFFF_FFFF, 1'b0));
    send_beat(make_beat(OP_EMPTY, 4095, 4095, 32'hFFFF_FFFF, 1'b1));
    send_beat(make_beat(OP_EMPTY, 0, 0, 32'h0, 1'b0));
    send_beat(make_beat(OP_NONZERO, 1, 9, 32'h0000_0001, 1'b1));
    // positive saturation, then a negative product onto the clamped value
    send_beat(make_beat(OP_NONZERO, 2, 100, 32'h8000_0000, 1'b0));
    send_beat(make_beat(OP_NONZERO, 2, 100, 32'h8000_0000, 1'b0));
    send_beat(make_beat(OP_NONZERO, 2, 100, 32'h7FFF_FFFF, 1'b1));
    // negative saturation
    send_beat(make_beat(OP_NONZERO, 2, 200, 32'h7FFF_FFFF, 1'b0));
    send_beat(make_beat(OP_NONZERO, 2, 200, 32'h7FFF_FFFF, 1'b0));
    send_beat(make_beat(OP_NONZERO, 2, 200, 32'h7FFF_FFFF, 1'b1));
    // unused operation with every bit set
    send_beat(make_beat(OP_UNUSED, 4095, 4095, 32'hFFFF_FFFF, 1'b1));
    send_beat(make_beat(OP_NONZERO, 0, 300, 32'h0001_0000, 1'b1));
  endtask

  // Vector length at its extremes, zero, above the store, and in between
  task automatic test_vector_length_settings();
    logic [VLEN_W-1:0] settings [6];
    settings = '{13'd1, 13'd0, 13'd8191, 13'd4096, 13'd2, 13'd4095};
    foreach (settings[i]) begin
      set_vector_length(settings[i]);
      // bad column at the limit itself when there is one
      if (int'(settings[i]) < VECTOR_DEPTH)
        send_beat(make_beat(OP_NONZERO, int'(settings[i]), 11, 32'h0001_0000, 1'b1));
      repeat (6) send_row($urandom_range(1, 4), 1'b0);
    end
  endtask

  // Bulk random traffic in phases, each at its own vector length
  task automatic test_random_stream();
    int start;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 3))
        0: set_vector_length(13'd4096);
        1: set_vector_length(VLEN_W'($urandom_range(1, 64)));
        default: set_vector_length(VLEN_W'($urandom_range(1, 4096)));
      endcase
      // one phase runs back to back on both sides
      src_idle_pct = (phase == 2) ? 0 : 33;
      sink_idle_pct = (phase == 2) ? 0 : 33;
      start = beats_sent;
      while (beats_sent - start < 120) send_random_item();
    end
    src_idle_pct = 33;
    sink_idle_pct = 33;
  endtask

  // Receiver holds off long enough that the block must stall its input
  task automatic test_backpressure();
    set_vector_length(13'd4096);
    src_idle_pct = 0;
    hold_req_len = 120;
    hold_req_seq++;
    repeat (20) send_row($urandom_range(1, 3), 1'b0);
    src_idle_pct = 33;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_vector_length_settings();
    test_backpressure();
    test_random_stream();

    // drain with a bound of its own so leftovers are reported
    in_valid <= 1'b0;
    repeat (5000) begin
      if (pending_sums.size() > 0) @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_sums.size() > 0) begin
      $display("%0d expected row sums never arrived", pending_sums.size());
      mismatches += pending_sums.size();
    end

    $display("Covered %0d input beats and %0d row sums (%0d with bad columns, %0d saturated).",
             beats_sent, sums_seen, bad_rows, saturated_sums);
    $display("Vector length written %0d times; input held off for %0d cycles.",
             vlen_writes, input_stalls);
    if (mismatches == 0) begin
      $display("[sparse_matrix_vector_multiply] OK");
    end else begin
      $display("%0d row sum failures", mismatches);
      $display("[sparse_matrix_vector_multiply] ERROR");
    end
    $finish;
  end

endmodule
